[hw/rtl/ogn_pkg.sv]
// ogn_pkg: shared constants, permutation ROM and helpers for the octave noise block.
// No dependencies.
package ogn_pkg;

    localparam int MAX_OCTAVES_DEF = 8;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int PROD_FRAC       = 24;

    typedef logic [1:0] shsel_t;
    localparam shsel_t SH_FRAC = 2'd0;
    localparam shsel_t SH_AMP  = 2'd1;
    localparam shsel_t SH_NONE = 2'd2;

    localparam logic [7:0] PERM_ROM [256] = '{
        8'd114, 8'd52, 8'd69, 8'd183, 8'd141, 8'd89, 8'd178, 8'd162,
        8'd112, 8'd133, 8'd214, 8'd26, 8'd77, 8'd72, 8'd224, 8'd55,
        8'd88, 8'd142, 8'd98, 8'd240, 8'd44, 8'd109, 8'd94, 8'd194,
        8'd30, 8'd118, 8'd22, 8'd150, 8'd110, 8'd132, 8'd242, 8'd107,
        8'd99, 8'd209, 8'd250, 8'd61, 8'd181, 8'd123, 8'd199, 8'd16,
        8'd197, 8'd170, 8'd62, 8'd137, 8'd58, 8'd128, 8'd145, 8'd87,
        8'd54, 8'd19, 8'd182, 8'd103, 8'd130, 8'd190, 8'd91, 8'd203,
        8'd212, 8'd241, 8'd217, 8'd180, 8'd237, 8'd189, 8'd81, 8'd7,
        8'd78, 8'd251, 8'd223, 8'd84, 8'd201, 8'd232, 8'd14, 8'd100,
        8'd74, 8'd144, 8'd167, 8'd119, 8'd249, 8'd158, 8'd231, 8'd230,
        8'd244, 8'd111, 8'd243, 8'd57, 8'd45, 8'd115, 8'd172, 8'd198,
        8'd161, 8'd126, 8'd131, 8'd42, 8'd166, 8'd80, 8'd134, 8'd90,
        8'd253, 8'd50, 8'd233, 8'd31, 8'd63, 8'd192, 8'd67, 8'd6,
        8'd156, 8'd220, 8'd179, 8'd12, 8'd28, 8'd160, 8'd76, 8'd23,
        8'd108, 8'd85, 8'd206, 8'd73, 8'd228, 8'd138, 8'd236, 8'd8,
        8'd153, 8'd38, 8'd34, 8'd202, 8'd196, 8'd39, 8'd48, 8'd226,
        8'd174, 8'd247, 8'd185, 8'd17, 8'd120, 8'd255, 8'd176, 8'd117,
        8'd49, 8'd210, 8'd1, 8'd122, 8'd218, 8'd106, 8'd124, 8'd175,
        8'd147, 8'd35, 8'd25, 8'd200, 8'd59, 8'd252, 8'd18, 8'd92,
        8'd66, 8'd47, 8'd60, 8'd154, 8'd152, 8'd3, 8'd159, 8'd246,
        8'd27, 8'd136, 8'd102, 8'd245, 8'd21, 8'd0, 8'd125, 8'd184,
        8'd171, 8'd157, 8'd13, 8'd82, 8'd116, 8'd51, 8'd188, 8'd143,
        8'd163, 8'd177, 8'd36, 8'd216, 8'd235, 8'd221, 8'd208, 8'd148,
        8'd64, 8'd5, 8'd222, 8'd97, 8'd186, 8'd139, 8'd146, 8'd33,
        8'd9, 8'd254, 8'd229, 8'd113, 8'd155, 8'd93, 8'd140, 8'd149,
        8'd173, 8'd104, 8'd86, 8'd127, 8'd68, 8'd234, 8'd95, 8'd151,
        8'd211, 8'd53, 8'd135, 8'd165, 8'd191, 8'd24, 8'd46, 8'd207,
        8'd227, 8'd2, 8'd238, 8'd187, 8'd219, 8'd96, 8'd11, 8'd65,
        8'd79, 8'd248, 8'd213, 8'd195, 8'd121, 8'd41, 8'd32, 8'd215,
        8'd105, 8'd20, 8'd129, 8'd239, 8'd164, 8'd168, 8'd10, 8'd43,
        8'd56, 8'd15, 8'd40, 8'd75, 8'd37, 8'd169, 8'd70, 8'd4,
        8'd205, 8'd225, 8'd29, 8'd204, 8'd101, 8'd83, 8'd71, 8'd193
    };

    // 2^8 = 1 mod 255: fold bytes, then one correction
    function automatic logic [7:0] mod255(input logic [39:0] v);
        logic [10:0] s;
        logic [8:0]  t;
        s = 11'(v[7:0]) + 11'(v[15:8]) + 11'(v[23:16]) + 11'(v[31:24]) + 11'(v[39:32]);
        t = 9'(s[10:8]) + 9'(s[7:0]);
        if (t >= 9'd255)
        begin
            t = t - 9'd255;
        end
        return t[7:0];
    endfunction

endpackage

[hw/rtl/ogn_mul.sv]
// ogn_mul: shared signed multiplier with registered, selectable arithmetic shift.
// Depends on ogn_pkg.
module ogn_mul #(
    parameter int W    = 22,
    parameter int FRAC = 16
) (
    input  logic                  clk,
    input  logic signed [W-1:0]   a,
    input  logic signed [W-1:0]   b,
    input  ogn_pkg::shsel_t       sh,
    output logic signed [2*W-1:0] p
);
    import ogn_pkg::*;

    logic signed [2*W-1:0] prod;
    logic signed [2*W-1:0] p_next;
    logic signed [2*W-1:0] p_reg;

    assign prod = a * b;

    always_comb
    begin
        case (sh)
            SH_FRAC: p_next = prod >>> FRAC;
            SH_AMP:  p_next = prod >>> 16;
            default: p_next = prod;
        endcase
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;
endmodule

[hw/rtl/ogn_div.sv]
// ogn_div: restoring divider, one quotient bit per cycle, unsigned operands.
// No dependencies.
module ogn_div #(
    parameter int NW = 40,
    parameter int DW = 21
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          done,
    output logic [NW-1:0] quo
);
    localparam int CW = $clog2(NW + 1);

    logic [DW:0]   rem_reg;
    logic [NW-1:0] num_reg;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] den_reg;
    logic [CW-1:0] cnt_reg;
    logic          run_reg;
    logic          done_reg;
    logic [DW:0]   trial;
    logic          fits;

    assign trial = {rem_reg[DW-1:0], num_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(NW - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            num_reg <= num;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            rem_reg <= fits ? (trial - {1'b0, den_reg}) : trial;
            num_reg <= {num_reg[NW-2:0], 1'b0};
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
endmodule

[hw/rtl/octave_gradient_noise_2d.sv]
// octave_gradient_noise_2d: fractal 2-D gradient noise, sequenced over one shared
// multiplier and a serial divider. Depends on ogn_pkg, ogn_mul, ogn_div.
//
// Usage:
//   Input: drive coord_x/coord_y (unsigned Q16.16) and pulse start while busy is
//   low; the item is taken at that edge and busy rises.
//   Output: done is high for exactly one cycle with noise_value (signed Q2.16).
//   The receiver cannot stall; the value is only guaranteed during done.
//   Config: cfg_we/cfg_index/cfg_data, write only while busy is low.
//   Index 0 octave_count, 1 persistence, 2 base_frequency; others ignored.
// Sequence:
//   the coordinates are scaled, then each octave runs in turn on the shared
//   multiplier, then the TW-bit weighted total (TW = FRAC_BITS + 20 +
//   clog2(MAX_OCTAVES+1), 40 at defaults) goes through the serial divider and
//   the result is registered. The next item may start in the cycle done is high.
// Reset: asynchronous, registers return to 4 / 32768 / 256, block idle.
module octave_gradient_noise_2d #(
    parameter int MAX_OCTAVES = ogn_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = ogn_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [31:0]        coord_x,
    input  logic [31:0]        coord_y,
    output logic               done,
    output logic signed [18:0] noise_value,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import ogn_pkg::*;

    localparam int MW  = (FRAC_BITS + 6 > 18) ? FRAC_BITS + 6 : 18;
    localparam int PW  = 2 * MW;
    localparam int OCW = $clog2(MAX_OCTAVES + 1);
    localparam int OIW = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
    localparam int SW  = 48 + MAX_OCTAVES - 1;
    localparam int TW  = FRAC_BITS + 20 + OCW;
    localparam int ASW = 17 + OCW;
    localparam int RW  = TW + 17;
    localparam int SH_DN = (FRAC_BITS >= 16) ? FRAC_BITS - 16 : 0;
    localparam int SH_UP = (FRAC_BITS < 16) ? 16 - FRAC_BITS : 0;

    localparam logic signed [MW-1:0] ONE = MW'(1) << FRAC_BITS;
    localparam logic signed [MW-1:0] K6  = MW'(6) << FRAC_BITS;
    localparam logic signed [MW-1:0] K15 = MW'(15) << FRAC_BITS;
    localparam logic signed [MW-1:0] K10 = MW'(10) << FRAC_BITS;
    localparam logic signed [RW-1:0] OUT_MAX = RW'(131072);

    localparam logic [1:0] CFG_OCT  = 2'd0;
    localparam logic [1:0] CFG_PERS = 2'd1;
    localparam logic [1:0] CFG_FREQ = 2'd2;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_SCX   = 5'd1;
    localparam logic [4:0] ST_SCY   = 5'd2;
    localparam logic [4:0] ST_MODX  = 5'd3;
    localparam logic [4:0] ST_MODY  = 5'd4;
    localparam logic [4:0] ST_H1    = 5'd5;
    localparam logic [4:0] ST_H2    = 5'd6;
    localparam logic [4:0] ST_FX1   = 5'd7;
    localparam logic [4:0] ST_FX2   = 5'd8;
    localparam logic [4:0] ST_FX3   = 5'd9;
    localparam logic [4:0] ST_FX4   = 5'd10;
    localparam logic [4:0] ST_FX5   = 5'd11;
    localparam logic [4:0] ST_FY1   = 5'd12;
    localparam logic [4:0] ST_FY2   = 5'd13;
    localparam logic [4:0] ST_FY3   = 5'd14;
    localparam logic [4:0] ST_FY4   = 5'd15;
    localparam logic [4:0] ST_FY5   = 5'd16;
    localparam logic [4:0] ST_L1    = 5'd17;
    localparam logic [4:0] ST_L2    = 5'd18;
    localparam logic [4:0] ST_L3    = 5'd19;
    localparam logic [4:0] ST_L4    = 5'd20;
    localparam logic [4:0] ST_W     = 5'd21;
    localparam logic [4:0] ST_A     = 5'd22;
    localparam logic [4:0] ST_NEXT  = 5'd23;
    localparam logic [4:0] ST_DIV   = 5'd24;
    localparam logic [4:0] ST_DWAIT = 5'd25;

    logic [4:0]  state_reg, state_next;
    logic [3:0]  oct_cnt_reg;
    logic [15:0] pers_reg;
    logic [15:0] bfreq_reg;

    logic [31:0] cx_reg, cy_reg;
    logic [SW-1:0] sx_reg, sy_reg;
    logic [7:0]  xi_reg, yi_reg, r0_reg, r1_reg;
    logic [FRAC_BITS-1:0] fx_reg, fy_reg;
    logic [3:0]  gbit_reg;
    logic signed [MW-1:0] tmp_reg, u_reg, v_reg, x1_reg, x2_reg;
    logic [16:0] amp_reg;
    logic [ASW-1:0] amp_sum_reg;
    logic signed [TW-1:0] total_reg;
    logic [OIW-1:0] oct_reg, last_reg;
    logic        done_reg;
    logic signed [18:0] noise_reg;

    logic [4:0]  ncl;
    logic [47:0] sc_prod;
    logic [SW-1:0] mod_src;
    logic [7:0]  mod_out;
    logic [7:0]  yi1;
    logic signed [MW-1:0] fxs, fxm, fys, fym, g00, g01, g10, g11, tsel, pq;
    logic signed [MW-1:0] mul_a, mul_b;
    shsel_t      mul_sh;
    logic signed [PW-1:0] mul_p;
    logic        tot_neg;
    logic [TW-1:0] tot_mag;
    logic        div_start, div_done;
    logic [TW-1:0] div_quo;
    logic signed [TW:0] qs;
    logic signed [RW-1:0] rs, rsat;

    assign ncl = (oct_cnt_reg == 4'd0) ? 5'd1 :
                 ({1'b0, oct_cnt_reg} > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) :
                 {1'b0, oct_cnt_reg};

    assign sc_prod = ((state_reg == ST_SCX) ? cx_reg : cy_reg) * bfreq_reg;
    assign mod_src = (state_reg == ST_MODX) ? sx_reg : sy_reg;
    assign mod_out = mod255(40'(mod_src[SW-1:PROD_FRAC]));
    assign yi1     = yi_reg + 8'd1;

    assign fxs = MW'(fx_reg);
    assign fys = MW'(fy_reg);
    assign fxm = fxs - ONE;
    assign fym = fys - ONE;
    assign g00 = gbit_reg[0] ? (fys - fxs) : (fxs + fys);
    assign g01 = gbit_reg[1] ? (fys - fxm) : (fxm + fys);
    assign g10 = gbit_reg[2] ? (fym - fxs) : (fxs + fym);
    assign g11 = gbit_reg[3] ? (fym - fxm) : (fxm + fym);

    assign pq   = mul_p[MW-1:0];
    assign tsel = (state_reg >= ST_FY1) ? fys : fxs;

    always_comb
    begin
        mul_a  = tsel;
        mul_b  = tsel;
        mul_sh = SH_FRAC;
        case (state_reg)
            ST_FX1, ST_FY1: mul_b = K6;
            ST_FX2, ST_FY2: mul_b = pq - K15;
            ST_FX4, ST_FY4: mul_a = pq;
            ST_FX5, ST_FY5:
            begin
                mul_a = pq;
                mul_b = tmp_reg;
            end
            ST_L1:
            begin
                mul_a = u_reg;
                mul_b = g01 - g00;
            end
            ST_L2:
            begin
                mul_a = u_reg;
                mul_b = g11 - g10;
            end
            ST_L4:
            begin
                mul_a = v_reg;
                mul_b = x2_reg - x1_reg;
            end
            ST_W:
            begin
                mul_a  = x1_reg + pq;
                mul_b  = MW'(amp_reg);
                mul_sh = SH_NONE;
            end
            ST_A:
            begin
                mul_a  = MW'(amp_reg);
                mul_b  = MW'(pers_reg);
                mul_sh = SH_AMP;
            end
            default: ;
        endcase
    end

    ogn_mul #(.W(MW), .FRAC(FRAC_BITS)) u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .sh  (mul_sh),
        .p   (mul_p)
    );

    assign tot_neg   = total_reg[TW-1];
    assign tot_mag   = tot_neg ? TW'(-total_reg) : TW'(total_reg);
    assign div_start = (state_reg == ST_DIV);

    ogn_div #(.NW(TW), .DW(ASW)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (tot_mag),
        .den   (amp_sum_reg),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_comb
    begin
        qs = $signed({1'b0, div_quo});
        if (tot_neg)
        begin
            qs = -qs;
        end
        if (FRAC_BITS >= 16)
        begin
            rs = RW'(qs) >>> SH_DN;
        end
        else
        begin
            rs = RW'(qs) <<< SH_UP;
        end
        if (rs > OUT_MAX)
        begin
            rsat = OUT_MAX;
        end
        else if (rs < -OUT_MAX)
        begin
            rsat = -OUT_MAX;
        end
        else
        begin
            rsat = rs;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCX;
                end
            end
            ST_NEXT:  state_next = (oct_reg == last_reg) ? ST_DIV : ST_MODX;
            ST_DWAIT: state_next = div_done ? ST_IDLE : ST_DWAIT;
            ST_DIV:   state_next = ST_DWAIT;
            default:  state_next = state_reg + 5'd1;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            done_reg    <= 1'b0;
            oct_cnt_reg <= 4'd4;
            pers_reg    <= 16'd32768;
            bfreq_reg   <= 16'd256;
            oct_reg     <= '0;
            last_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_DWAIT) && div_done;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_OCT:  oct_cnt_reg <= cfg_data[3:0];
                    CFG_PERS: pers_reg    <= cfg_data;
                    CFG_FREQ: bfreq_reg   <= cfg_data;
                    default:  ;
                endcase
            end
            if (state_reg == ST_IDLE && start)
            begin
                oct_reg  <= '0;
                last_reg <= OIW'(ncl - 5'd1);
            end
            else if (state_reg == ST_NEXT)
            begin
                oct_reg <= oct_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                cx_reg      <= coord_x;
                cy_reg      <= coord_y;
                total_reg   <= '0;
                amp_sum_reg <= '0;
                amp_reg     <= 17'd65536;
            end
            ST_SCX:  sx_reg <= SW'(sc_prod);
            ST_SCY:  sy_reg <= SW'(sc_prod);
            ST_MODX:
            begin
                xi_reg <= mod_out;
                fx_reg <= sx_reg[PROD_FRAC-1 -: FRAC_BITS];
            end
            ST_MODY:
            begin
                yi_reg <= mod_out;
                fy_reg <= sy_reg[PROD_FRAC-1 -: FRAC_BITS];
            end
            ST_H1:
            begin
                r0_reg <= PERM_ROM[xi_reg];
                r1_reg <= PERM_ROM[xi_reg + 8'd1];
            end
            ST_H2:
            begin
                gbit_reg[0] <= PERM_ROM[r0_reg + yi_reg][0];
                gbit_reg[1] <= PERM_ROM[r0_reg + yi1][0];
                gbit_reg[2] <= PERM_ROM[r1_reg + yi_reg][0];
                gbit_reg[3] <= PERM_ROM[r1_reg + yi1][0];
            end
            ST_FX3, ST_FY3: tmp_reg <= pq + K10;
            ST_FY1: u_reg  <= pq;
            ST_L1:  v_reg  <= pq;
            ST_L2:  x1_reg <= g00 + pq;
            ST_L3:  x2_reg <= g10 + pq;
            ST_A:
            begin
                total_reg   <= total_reg + TW'(mul_p);
                amp_sum_reg <= amp_sum_reg + ASW'(amp_reg);
            end
            ST_NEXT:
            begin
                amp_reg <= mul_p[16:0];
                sx_reg  <= {sx_reg[SW-2:0], 1'b0};
                sy_reg  <= {sy_reg[SW-2:0], 1'b0};
            end
            ST_DWAIT: noise_reg <= 19'(rsat);
            default: ;
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign noise_value = noise_reg;
endmodule

[hw/rtl/ogn_checker.sv]
// ogn_checker: port-level assertions for octave_gradient_noise_2d, plus its bind.
// Depends on octave_gradient_noise_2d port list only.
module ogn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic signed [18:0] noise_value
);
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted item did not raise busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without an item in work");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (noise_value <= 19'sd131072) && (noise_value >= -19'sd131072))
        else $error("noise value out of range");
endmodule

bind octave_gradient_noise_2d ogn_checker u_ogn_checker (.*);

[dv/octave_gradient_noise_2d_test.sv]
// Self-checking testbench for octave_gradient_noise_2d: random and directed points
// over several register settings, checked against an in-bench fixed-point noise model.
// Depends on ogn_pkg and the octave_gradient_noise_2d RTL.
module octave_gradient_noise_2d_test;
    timeunit 1ns;
    timeprecision 1ps;

    import ogn_pkg::*;

    localparam longint ONE_Q     = 64'sd65536;
    localparam int     SETTLE    = 240;
    localparam int     WDOG_MAX  = 4000;
    localparam logic [1:0] REG_OCTAVES = 2'd0;
    localparam logic [1:0] REG_PERSIST = 2'd1;
    localparam logic [1:0] REG_BASEFRQ = 2'd2;
    localparam logic [1:0] REG_UNUSED  = 2'd3;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
    } point_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [31:0]        coord_x = '0;
    logic [31:0]        coord_y = '0;
    logic               done;
    logic signed [18:0] noise_value;
    logic               cfg_we = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [15:0]        cfg_data = '0;

    point_t      point_q[$];
    logic [18:0] noise_q[$];
    logic [3:0]  oct_reg = 4'd4;
    logic [15:0] pers_reg = 16'd32768;
    logic [15:0] freq_reg = 16'd256;
    int          idle_pct = 0;
    int          err_cnt = 0;
    int          pts_sent = 0;
    int          res_seen = 0;
    int          wdog = 0;

    octave_gradient_noise_2d u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .coord_x(coord_x), .coord_y(coord_y), .done(done), .noise_value(noise_value),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic longint qmul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic longint fade(longint t);
        longint inner;
        longint t3;
        inner = qmul(t, qmul(t, 6 * ONE_Q) - 15 * ONE_Q) + 10 * ONE_Q;
        t3 = qmul(qmul(t, t), t);
        return qmul(t3, inner);
    endfunction

    function automatic longint grad(logic [7:0] h, longint gx, longint gy);
        return h[0] ? (gy - gx) : (gx + gy);
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return a + qmul(w, b - a);
    endfunction

    function automatic logic [7:0] hash(logic [8:0] a, logic [8:0] b);
        logic [7:0] k;
        k = PERM_ROM[a[7:0]] + b[7:0];
        return PERM_ROM[k];
    endfunction

    function automatic longint octave_noise(logic [63:0] sx, logic [63:0] sy);
        logic [8:0] xi;
        logic [8:0] yi;
        longint     fx;
        longint     fy;
        longint     u;
        longint     v;
        longint     x1;
        longint     x2;
        xi = 9'((sx >> 24) % 255);
        yi = 9'((sy >> 24) % 255);
        fx = longint'({48'b0, sx[23:8]});
        fy = longint'({48'b0, sy[23:8]});
        u = fade(fx);
        v = fade(fy);
        x1 = blend(grad(hash(xi, yi), fx, fy), grad(hash(xi, yi + 1), fx - ONE_Q, fy), u);
        x2 = blend(grad(hash(xi + 1, yi), fx, fy - ONE_Q),
                   grad(hash(xi + 1, yi + 1), fx - ONE_Q, fy - ONE_Q), u);
        return blend(x1, x2, v);
    endfunction

    function automatic logic [18:0] fractal_noise(point_t p);
        int          n;
        longint      total;
        longint      amp_sum;
        logic [63:0] amp;
        logic [63:0] sx;
        logic [63:0] sy;
        longint      r;
        n = (oct_reg == 0) ? 1 : ((oct_reg > 8) ? 8 : int'(oct_reg));
        total = 0;
        amp_sum = 0;
        amp = 64'd65536;
        for (int i = 0; i < n; i++)
        begin
            sx = ({32'b0, p.x} * {48'b0, freq_reg}) << i;
            sy = ({32'b0, p.y} * {48'b0, freq_reg}) << i;
            total += octave_noise(sx, sy) * longint'(amp);
            amp_sum += longint'(amp);
            amp = (amp * {48'b0, pers_reg}) >> 16;
        end
        r = total / amp_sum;
        if (r > 131072)
            r = 131072;
        if (r < -131072)
            r = -131072;
        return r[18:0];
    endfunction

    // driver: presents queued points, holds while busy
    always @(posedge clk)
    begin
        point_t nxt;
        if (start && !busy)
        begin
            noise_q.push_back(fractal_noise(point_q.pop_front()));
            pts_sent++;
        end
        if (start && busy)
        begin
            start <= 1'b1;
        end
        else if (rst_n && point_q.size() > 0 && $urandom_range(99) >= idle_pct)
        begin
            nxt = point_q[0];
            start <= 1'b1;
            coord_x <= nxt.x;
            coord_y <= nxt.y;
        end
        else
        begin
            start <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        logic [18:0] want;
        if (done)
        begin
            res_seen++;
            if (noise_q.size() == 0)
            begin
                $error("noise_value: unexpected result %0d", noise_value);
                err_cnt++;
            end
            else
            begin
                want = noise_q.pop_front();
                if (noise_value !== want)
                begin
                    $error("noise_value: expected %0d actual %0d",
                           $signed(want), noise_value);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog >= WDOG_MAX)
        begin
            $display("octave_gradient_noise_2d_test: errors");
            $finish;
        end
    end

    task automatic drain();
        while (point_q.size() > 0 || noise_q.size() > 0 || start)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic reg_write(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        case (idx)
            REG_OCTAVES: oct_reg = val[3:0];
            REG_PERSIST: pers_reg = val;
            REG_BASEFRQ: freq_reg = val;
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic setup(logic [15:0] oc, logic [15:0] pe, logic [15:0] bf);
        drain();
        reg_write(REG_OCTAVES, oc);
        reg_write(REG_PERSIST, pe);
        reg_write(REG_BASEFRQ, bf);
    endtask

    task automatic add_point(logic [31:0] x, logic [31:0] y);
        point_t p;
        p.x = x;
        p.y = y;
        point_q.push_back(p);
    endtask

    task automatic random_points(int cnt);
        for (int k = 0; k < cnt; k++)
        begin
            case ($urandom_range(3))
                0: add_point($urandom_range(32'h00FF_FFFF), $urandom_range(32'h00FF_FFFF));
                1: add_point({16'($urandom_range(253, 256)), 16'($urandom)},
                             {16'($urandom_range(253, 256)), 16'($urandom)});
                default: add_point($urandom, $urandom);
            endcase
        end
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults after reset, directed corners
        add_point(32'h0, 32'h0);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_point(32'hFFFF_FFFF, 32'h0);
        add_point(32'h0, 32'hFFFF_FFFF);
        add_point(32'h0000_FFFF, 32'h0000_8000);
        add_point(32'h00FE_0000, 32'h00FF_0000);
        add_point(32'h00FF_FFFF, 32'h0100_0000);
        add_point(32'h5555_5555, 32'hAAAA_AAAA);
        add_point(32'hAAAA_AAAA, 32'h5555_5555);
        add_point(32'h0000_0001, 32'h0001_0000);
        setup(16'd1, 16'd0, 16'd1);
        add_point(32'hFFFF_FFFF, 32'h1234_5678);
        add_point(32'h8000_0000, 32'h8000_0000);
        setup(16'd8, 16'd65535, 16'd65535);
        add_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_point(32'h0001_8000, 32'h0002_4000);
        setup(16'd0, 16'd0, 16'd0);
        add_point(32'h1234_5678, 32'h9ABC_DEF0);
        setup(16'd15, 16'd32768, 16'd256);
        add_point(32'h0003_C000, 32'h0007_2000);
        setup(16'hFFF9, 16'hFFFF, 16'h0080);
        reg_write(REG_UNUSED, 16'hFFFF);
        add_point(32'h00FF_8000, 32'h0000_4000);
        drain();
        reg_write(REG_UNUSED, 16'h0000);

        idle_pct = 0;
        setup(16'd4, 16'd32768, 16'd256);
        random_points(100);
        idle_pct = 60;
        setup(16'($urandom_range(1, 8)), 16'($urandom), 16'($urandom_range(1, 65535)));
        random_points(100);
        idle_pct = 32;
        setup(16'd8, 16'd65535, 16'd1);
        random_points(60);
        idle_pct = 0;
        setup(16'd2, 16'd1, 16'd65535);
        random_points(60);
        idle_pct = 60;
        setup(16'($urandom_range(0, 15)), 16'($urandom), 16'($urandom));
        random_points(80);
        drain();

        $display("covered %0d points, %0d results, octave counts 0..15, register extremes",
                 pts_sent, res_seen);
        if (err_cnt == 0)
            $display("octave_gradient_noise_2d_test: clean");
        else
            $display("octave_gradient_noise_2d_test: errors");
        $finish;
    end
endmodule

[files.f]
hw/rtl/ogn_pkg.sv
hw/rtl/ogn_mul.sv
hw/rtl/ogn_div.sv
hw/rtl/octave_gradient_noise_2d.sv
hw/rtl/ogn_checker.sv
dv/octave_gradient_noise_2d_test.sv
